FILE: src/assert_macros.svh
// Assertion helpers. Each use needs clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPLIES(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: src/swtfs_pkg.sv
`default_nettype none

package swtfs_pkg;

    // default sizes
    localparam int VALUE_RANGE_DEF = 64;
    localparam int MAX_WINDOW_DEF  = 64;
    localparam int TOP_MAX_DEF     = 16;

    // port field widths
    localparam int SAMPLE_W   = 6;
    localparam int WLEN_W     = 7;
    localparam int TOPC_W     = 5;
    localparam int SUM_W      = 12;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 7;

    localparam logic [SUM_W-1:0] SUM_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_COUNT     = 1'b1;

    typedef struct packed {
        logic clear;
        logic we;
    } hist_op_t;

    typedef struct packed {
        logic clear;
        logic insert;
        logic pop;
    } topk_op_t;

endpackage

`default_nettype wire

FILE: src/swtfs_hist.sv
`default_nettype none

// Histogram store: one write and one registered read per cycle,
// per-bin valid bits so a bin never written since clear reads zero.
module swtfs_hist
    import swtfs_pkg::*;
#(
    parameter int VALUE_RANGE = VALUE_RANGE_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF
)
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire hist_op_t                            op,
    input  wire logic [$clog2(VALUE_RANGE)-1:0]      wr_addr,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]     wr_data,
    input  wire logic [$clog2(VALUE_RANGE)-1:0]      rd_addr,
    output logic      [$clog2(MAX_WINDOW+1)-1:0]     rd_data
);

    localparam int CW = $clog2(MAX_WINDOW + 1);

    logic [CW-1:0]          mem [VALUE_RANGE];
    logic [CW-1:0]          data_reg;
    logic [VALUE_RANGE-1:0] vld_reg;
    logic                   vld_q_reg;

    always_ff @(posedge clk)
    begin
        if (op.we)
        begin
            mem[wr_addr] <= wr_data;
        end
        data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg   <= '0;
            vld_q_reg <= 1'b0;
        end
        else
        begin
            if (op.clear)
            begin
                vld_reg <= '0;
            end
            else if (op.we)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            vld_q_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = vld_q_reg ? data_reg : '0;

endmodule

`default_nettype wire

FILE: src/swtfs_topk.sv
`default_nettype none

// Sorted list of the best keys seen, key = {count, value}, highest first.
// Insert places one key per cycle; pop shifts the head out.
module swtfs_topk
    import swtfs_pkg::*;
#(
    parameter int VALUE_RANGE = VALUE_RANGE_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int TOP_MAX     = TOP_MAX_DEF
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire topk_op_t                           op,
    input  wire logic [$clog2(MAX_WINDOW+1)-1:0]    in_count,
    input  wire logic [$clog2(VALUE_RANGE)-1:0]     in_value,
    output logic                                    head_occ,
    output logic      [$clog2(MAX_WINDOW+1)-1:0]    head_count,
    output logic      [$clog2(VALUE_RANGE)-1:0]     head_value
);

    localparam int VW = $clog2(VALUE_RANGE);
    localparam int CW = $clog2(MAX_WINDOW + 1);
    localparam int KW = CW + VW;

    logic [KW-1:0]      key_reg  [TOP_MAX];
    logic [KW-1:0]      key_next [TOP_MAX];
    logic [TOP_MAX-1:0] occ_reg;
    logic [TOP_MAX-1:0] occ_next;
    logic [TOP_MAX-1:0] gt;
    logic [KW-1:0]      key_in;

    assign key_in = {in_count, in_value};

    always_comb
    begin
        for (int i = 0; i < TOP_MAX; i++)
        begin
            gt[i]       = !occ_reg[i] || (key_in > key_reg[i]);
            key_next[i] = key_reg[i];
            occ_next[i] = occ_reg[i];
        end
        if (op.clear)
        begin
            occ_next = '0;
        end
        else if (op.insert)
        begin
            // list is sorted, so gt is zeros then ones
            if (gt[0])
            begin
                key_next[0] = key_in;
                occ_next[0] = 1'b1;
            end
            for (int i = 1; i < TOP_MAX; i++)
            begin
                if (gt[i] && !gt[i-1])
                begin
                    key_next[i] = key_in;
                    occ_next[i] = 1'b1;
                end
                else if (gt[i])
                begin
                    key_next[i] = key_reg[i-1];
                    occ_next[i] = occ_reg[i-1];
                end
            end
        end
        else if (op.pop)
        begin
            for (int i = 0; i < TOP_MAX - 1; i++)
            begin
                key_next[i] = key_reg[i+1];
                occ_next[i] = occ_reg[i+1];
            end
            occ_next[TOP_MAX-1] = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < TOP_MAX; i++)
        begin
            key_reg[i] <= key_next[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= '0;
        end
        else
        begin
            occ_reg <= occ_next;
        end
    end

    assign head_occ   = occ_reg[0];
    assign head_count = key_reg[0][KW-1:VW];
    assign head_value = key_reg[0][VW-1:0];

endmodule

`default_nettype wire

FILE: src/sliding_window_top_x_frequency_sum.sv
`default_nettype none

// Channel | Direction | Handshake           | Payload
// --------+-----------+---------------------+------------------------------
// in      | in        | in_valid / in_ready | sample_value, sequence_start
// out     | out       | out_valid/out_ready | window_sum
// cfg     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
// An item passes through the delay line and histogram update in states
// RDOLD, DEC, RDNEW and INC (one histogram port: read old, write decrement,
// read new, write increment). Once the window is full it then scans all
// bins into the top-k insertion list, drains the picks through the shared
// multiply-accumulate (picks = selected entries, at most top_count) and
// loads the output register.
// The next item is taken in the idle state after that.
// in_ready is high only in idle; a finished item may wait in the output
// register while the next item is taken. No clearing pass after reset.
// cfg_ready is always high; writes are expected only while idle.

`include "assert_macros.svh"

module sliding_window_top_x_frequency_sum
    import swtfs_pkg::*;
#(
    parameter int VALUE_RANGE = VALUE_RANGE_DEF,
    parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
    parameter int TOP_MAX     = TOP_MAX_DEF
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [SAMPLE_W-1:0]   sample_value,
    input  wire logic                  sequence_start,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic      [SUM_W-1:0]      window_sum,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int VW   = $clog2(VALUE_RANGE);
    localparam int CW   = $clog2(MAX_WINDOW + 1);      // counts, fill, length
    localparam int PW   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
    localparam int KW   = $clog2(TOP_MAX + 1);
    localparam int SCW  = $clog2(VALUE_RANGE + 1);
    localparam int PRW  = CW + VW;
    localparam int AW   = ((PRW > SUM_W) ? PRW : SUM_W) + 1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RDOLD = 3'd1;
    localparam logic [2:0] S_DEC   = 3'd2;
    localparam logic [2:0] S_RDNEW = 3'd3;
    localparam logic [2:0] S_INC   = 3'd4;
    localparam logic [2:0] S_SCAN  = 3'd5;
    localparam logic [2:0] S_SUM   = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0]        state_reg, state_next;

    logic [WLEN_W-1:0] wlen_reg;
    logic [TOPC_W-1:0] topc_reg;
    logic [CW-1:0]     len_eff;
    logic [KW-1:0]     picks_eff;

    logic [CW-1:0]     fill_reg;
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     wp_eff;
    logic [31:0]       wp_inc;
    logic [VW-1:0]     v_in;
    logic [VW-1:0]     v_reg;
    logic              evict_reg;
    logic              in_acc;
    logic              cfg_acc;
    logic              seq_clear;
    logic              has_result;

    // delay line
    logic [VW-1:0]     win_mem [MAX_WINDOW];
    logic [VW-1:0]     win_q;

    // histogram
    hist_op_t          hist_op;
    logic [VW-1:0]     hist_wr_addr;
    logic [CW-1:0]     hist_wr_data;
    logic [VW-1:0]     hist_rd_addr;
    logic [CW-1:0]     hist_rd_data;

    // scan
    logic [SCW-1:0]    scan_cnt_reg;
    logic              scan_vld_reg;
    logic [VW-1:0]     scan_val_reg;
    logic              scan_last;

    // top-k and accumulate
    topk_op_t          topk_op;
    logic              head_occ;
    logic [CW-1:0]     head_count;
    logic [VW-1:0]     head_value;
    logic [KW-1:0]     picks_reg;
    logic              issue;
    logic [PRW-1:0]    prod_reg;
    logic              prod_vld_reg;
    logic [SUM_W-1:0]  acc_reg;
    logic [AW-1:0]     acc_sum;

    logic              out_valid_reg;
    logic [SUM_W-1:0]  sum_out_reg;
    logic              out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign cfg_acc   = cfg_valid && cfg_ready;
    assign out_valid  = out_valid_reg;
    assign window_sum = sum_out_reg;

    // effective register values: zero length means one, both clamp high
    always_comb
    begin
        if (wlen_reg == '0)
        begin
            len_eff = CW'(1);
        end
        else if (32'(wlen_reg) > MAX_WINDOW)
        begin
            len_eff = CW'(MAX_WINDOW);
        end
        else
        begin
            len_eff = CW'(wlen_reg);
        end

        if (32'(topc_reg) > TOP_MAX)
        begin
            picks_eff = KW'(TOP_MAX);
        end
        else
        begin
            picks_eff = KW'(topc_reg);
        end

        if (32'(sample_value) >= VALUE_RANGE)
        begin
            v_in = VW'(VALUE_RANGE - 1);
        end
        else
        begin
            v_in = VW'(sample_value);
        end
    end

    assign wp_eff = (sequence_start || (32'(wp_reg) >= 32'(len_eff))) ? '0 : wp_reg;
    assign wp_inc = 32'(wp_reg) + 32'd1;
    assign has_result = evict_reg || ((32'(fill_reg) + 32'd1) >= 32'(len_eff));
    assign seq_clear  = (in_acc && sequence_start)
                     || (cfg_acc && (cfg_index == CFG_WINDOW_LENGTH));

    // delay line: read the slot about to be overwritten, write in DEC
    always_ff @(posedge clk)
    begin
        if (state_reg == S_DEC)
        begin
            win_mem[wp_reg] <= v_reg;
        end
        if (in_acc)
        begin
            win_q <= win_mem[wp_eff];
        end
    end

    // histogram port steering
    always_comb
    begin
        hist_op.clear = seq_clear;
        hist_op.we    = 1'b0;
        hist_wr_addr  = v_reg;
        hist_wr_data  = hist_rd_data + CW'(1);
        hist_rd_addr  = v_reg;
        unique case (state_reg)
            S_RDOLD:
            begin
                hist_rd_addr = win_q;
            end
            S_DEC:
            begin
                // evicted value leaves the window
                hist_op.we   = evict_reg && (hist_rd_data != '0);
                hist_wr_addr = win_q;
                hist_wr_data = hist_rd_data - CW'(1);
            end
            S_INC:
            begin
                hist_op.we = 1'b1;
            end
            S_SCAN:
            begin
                hist_rd_addr = scan_cnt_reg[VW-1:0];
            end
            default:
            begin
            end
        endcase
    end

    swtfs_hist #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_WINDOW  (MAX_WINDOW)
    ) u_hist (
        .clk     (clk),
        .rst_n   (rst_n),
        .op      (hist_op),
        .wr_addr (hist_wr_addr),
        .wr_data (hist_wr_data),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    assign scan_last = (32'(scan_cnt_reg) == VALUE_RANGE);
    assign issue     = (state_reg == S_SUM) && (picks_reg != '0) && head_occ;

    assign topk_op.clear  = (state_reg == S_INC);
    assign topk_op.insert = (state_reg == S_SCAN) && scan_vld_reg && (hist_rd_data != '0);
    assign topk_op.pop    = issue;

    swtfs_topk #(
        .VALUE_RANGE (VALUE_RANGE),
        .MAX_WINDOW  (MAX_WINDOW),
        .TOP_MAX     (TOP_MAX)
    ) u_topk (
        .clk        (clk),
        .rst_n      (rst_n),
        .op         (topk_op),
        .in_count   (hist_rd_data),
        .in_value   (scan_val_reg),
        .head_occ   (head_occ),
        .head_count (head_count),
        .head_value (head_value)
    );

    // saturating accumulate of the registered product
    assign acc_sum = AW'(acc_reg) + AW'(prod_reg);

    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = S_RDOLD;
                end
            end
            S_RDOLD: state_next = S_DEC;
            S_DEC:   state_next = S_RDNEW;
            S_RDNEW: state_next = S_INC;
            S_INC:   state_next = has_result ? S_SCAN : S_IDLE;
            S_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = S_SUM;
                end
            end
            S_SUM:
            begin
                if (!issue && !prod_vld_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_load)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            v_reg <= v_in;
        end
        if (state_reg == S_SCAN)
        begin
            scan_val_reg <= scan_cnt_reg[VW-1:0];
        end
        if (issue)
        begin
            prod_reg <= PRW'(head_count) * PRW'(head_value);
        end
        if (out_load)
        begin
            sum_out_reg <= acc_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wlen_reg      <= WLEN_W'(1);
            topc_reg      <= TOPC_W'(1);
            fill_reg      <= '0;
            wp_reg        <= '0;
            evict_reg     <= 1'b0;
            scan_cnt_reg  <= '0;
            scan_vld_reg  <= 1'b0;
            picks_reg     <= '0;
            prod_vld_reg  <= 1'b0;
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            if (in_acc)
            begin
                wp_reg    <= wp_eff;
                fill_reg  <= sequence_start ? '0 : fill_reg;
                evict_reg <= !sequence_start && (fill_reg >= len_eff);
            end

            if (state_reg == S_INC)
            begin
                wp_reg <= (wp_inc >= 32'(len_eff)) ? '0 : PW'(wp_inc);
                if (!evict_reg)
                begin
                    fill_reg <= fill_reg + CW'(1);
                end
                scan_cnt_reg <= '0;
                scan_vld_reg <= 1'b0;
                acc_reg      <= '0;
                prod_vld_reg <= 1'b0;
                picks_reg    <= picks_eff;
            end

            if (state_reg == S_SCAN)
            begin
                scan_vld_reg <= !scan_last;
                if (!scan_last)
                begin
                    scan_cnt_reg <= scan_cnt_reg + SCW'(1);
                end
            end

            if (state_reg == S_SUM)
            begin
                prod_vld_reg <= issue;
                if (issue)
                begin
                    picks_reg <= picks_reg - KW'(1);
                end
                if (prod_vld_reg)
                begin
                    acc_reg <= (acc_sum > AW'(SUM_MAX)) ? SUM_MAX : acc_sum[SUM_W-1:0];
                end
            end

            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            // configuration; a new window length restarts the sequence
            if (cfg_acc)
            begin
                unique case (cfg_index)
                    CFG_WINDOW_LENGTH:
                    begin
                        wlen_reg <= cfg_data[WLEN_W-1:0];
                        fill_reg <= '0;
                        wp_reg   <= '0;
                    end
                    CFG_TOP_COUNT:
                    begin
                        topc_reg <= cfg_data[TOPC_W-1:0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // fill never passes the window between items
    `ASSERT_IMPLIES(a_fill_bound, state_reg == S_IDLE, fill_reg <= len_eff)
    // write pointer stays inside the window between items
    `ASSERT_IMPLIES(a_wp_bound, state_reg == S_IDLE, 32'(wp_reg) < 32'(len_eff))
    // multiply pipeline drains before the sum leaves
    `ASSERT_IMPLIES(a_prod_drain, prod_vld_reg, state_reg == S_SUM)
    // a scan always ends in the accumulate phase
    `ASSERT_NEXT(a_scan_to_sum, state_reg == S_SCAN && scan_last, state_reg == S_SUM)

endmodule

`default_nettype wire

FILE: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import swtfs_pkg::*;

    // Covers the longest item, padded for the quiet spells.
    localparam int SETTLE_CYCLES = VALUE_RANGE_DEF + TOP_MAX_DEF + 16;
    // Cycles with no handshake at all before the run is declared hung.
    localparam int STALL_LIMIT   = 6000;
    // Receiver hold-off long enough to back the block up into its input.
    localparam int LONG_HOLD     = 1200;
    localparam int RANDOM_ITEMS  = 1750;

    typedef struct packed {
        logic [SAMPLE_W-1:0] value;
        logic                start;
    } sample_item_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                  in_valid       = 1'b0;
    logic                  in_ready;
    logic [SAMPLE_W-1:0]   sample_value   = '0;
    logic                  sequence_start = 1'b0;
    logic                  out_valid;
    logic                  out_ready      = 1'b0;
    logic [SUM_W-1:0]      window_sum;
    logic                  cfg_valid      = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index      = '0;
    logic [CFG_DATA_W-1:0] cfg_data       = '0;

    sliding_window_top_x_frequency_sum dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .sample_value   (sample_value),
        .sequence_start (sequence_start),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .window_sum     (window_sum),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Shared between stimulus, driver, receiver and checker
    // ------------------------------------------------------------------
    sample_item_t    pending_samples[$];   // items waiting for the driver
    logic [SUM_W-1:0] sums_due[$];         // predicted sums, oldest first
    bit  no_idle       = 1'b0;             // burst stretch: neither side idles
    int  hold_requests = 0;                // bumped to ask for a long hold-off
    bit  in_accepted   = 1'b0;
    bit  out_accepted  = 1'b0;

    int  fails        = 0;
    int  items_in     = 0;
    int  results_out  = 0;
    int  cfg_writes   = 0;
    int  starts_taken = 0;
    int  long_holds   = 0;

    // ------------------------------------------------------------------
    // Predictor: own copy of the delay line, histogram and registers
    // ------------------------------------------------------------------
    logic [WLEN_W-1:0]   wlen_reg = 7'd1;
    logic [TOPC_W-1:0]   topc_reg = 5'd1;
    logic [SAMPLE_W-1:0] win_vals[MAX_WINDOW_DEF];
    int                  hist[VALUE_RANGE_DEF];
    int                  fill_cnt = 0;
    int                  wr_ptr   = 0;

    function automatic void clear_hist();
        foreach (hist[i])
            hist[i] = 0;
        fill_cnt = 0;
        wr_ptr   = 0;
    endfunction

    // Pick the most frequent values one at a time; on equal counts the
    // higher value goes first, hence >= while scanning upwards.
    function automatic logic [SUM_W-1:0] ranked_sum(int picks);
        bit taken[VALUE_RANGE_DEF];
        int total;
        int best;
        bit found;
        total = 0;
        foreach (taken[i])
            taken[i] = 1'b0;
        for (int p = 0; p < picks; p++)
        begin
            found = 1'b0;
            best  = 0;
            for (int v = 0; v < VALUE_RANGE_DEF; v++)
                if (!taken[v] && hist[v] != 0 && (!found || hist[v] >= hist[best]))
                begin
                    best  = v;
                    found = 1'b1;
                end
            if (!found)
                break;
            taken[best] = 1'b1;
            total += hist[best] * best;
            if (total > SUM_MAX)
                total = SUM_MAX;
        end
        return total[SUM_W-1:0];
    endfunction

    // Slide one value in; returns 1 when the window is full and a sum is due.
    function automatic bit advance_window(input logic [SAMPLE_W-1:0] v, input logic start,
                                          output logic [SUM_W-1:0] sum);
        int len;
        int picks;
        int old;
        len   = (wlen_reg == 0) ? 1 :
                (wlen_reg > MAX_WINDOW_DEF) ? MAX_WINDOW_DEF : int'(wlen_reg);
        picks = (topc_reg > TOP_MAX_DEF) ? TOP_MAX_DEF : int'(topc_reg);
        if (start)
            clear_hist();
        if (wr_ptr >= len)
            wr_ptr = 0;
        if (fill_cnt >= len)
        begin
            old = win_vals[wr_ptr];
            if (hist[old] > 0)
                hist[old]--;
        end
        else
            fill_cnt++;
        win_vals[wr_ptr] = v;
        hist[v]++;
        wr_ptr++;
        if (wr_ptr >= len)
            wr_ptr = 0;
        sum = ranked_sum(picks);
        return fill_cnt >= len;
    endfunction

    // ------------------------------------------------------------------
    // Checker: samples every handshake at the rising edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        logic [SUM_W-1:0] predicted;
        logic [SUM_W-1:0] oldest;
        in_accepted  <= rst_n && in_valid && in_ready;
        out_accepted <= rst_n && out_valid && out_ready;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                cfg_writes++;
                if (cfg_index == CFG_WINDOW_LENGTH)
                begin
                    wlen_reg = cfg_data[WLEN_W-1:0];
                    clear_hist();   // new window length starts a fresh sequence
                end
                else if (cfg_index == CFG_TOP_COUNT)
                    topc_reg = cfg_data[TOPC_W-1:0];
            end
            // results first, so a sum queued this edge cannot be matched this edge
            if (out_valid && out_ready)
            begin
                results_out++;
                if (sums_due.size() == 0)
                begin
                    $error("window_sum: unexpected result %0d", window_sum);
                    fails++;
                end
                else
                begin
                    oldest = sums_due.pop_front();
                    if (window_sum !== oldest)
                    begin
                        $error("window_sum: expected %0d, got %0d", oldest, window_sum);
                        fails++;
                    end
                end
            end
            if (in_valid && in_ready)
            begin
                items_in++;
                if (sequence_start)
                    starts_taken++;
                if (advance_window(sample_value, sequence_start, predicted))
                    sums_due = {sums_due, predicted};
            end
        end
    end

    // ------------------------------------------------------------------
    // Driver: next item at the falling edge once the last was taken
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int           gap_left;
        sample_item_t next_item;
        if (rst_n)
        begin
            if (in_valid && !in_accepted)
                ;                           // still offered, payload held
            else if (gap_left > 0)
            begin
                in_valid <= 1'b0;
                gap_left--;
            end
            else if (pending_samples.size() != 0)
            begin
                next_item      = pending_samples.pop_front();
                sample_value   <= next_item.value;
                sequence_start <= next_item.start;
                in_valid       <= 1'b1;
                gap_left       = no_idle ? 0 : $urandom_range(0, 16);
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Receiver: random stall after each result, plus the odd long hold
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        int stall_left;
        int holds_served;
        if (rst_n)
        begin
            if (out_accepted)
                stall_left = no_idle ? 0 : $urandom_range(0, 16);
            if (holds_served != hold_requests)
            begin
                holds_served++;
                stall_left = LONG_HOLD;
                long_holds++;
            end
            out_ready <= (stall_left == 0);
            if (stall_left > 0)
                stall_left--;
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: too long without any handshake means the block is stuck
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        int quiet;
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready))
            quiet = 0;
        else
        begin
            quiet++;
            if (quiet == STALL_LIMIT)
            begin
                $display("[sliding_window_top_x_frequency_sum] ERROR");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    logic [SAMPLE_W-1:0] palette[3];

    task automatic queue_sample(input logic [SAMPLE_W-1:0] v, input logic start);
        sample_item_t s;
        s.value = v;
        s.start = start;
        pending_samples = {pending_samples, s};
    endtask

    // Sender pauses until every predicted sum has come back.
    task automatic wait_all_results();
        do
            @(posedge clk);
        while (pending_samples.size() != 0 || in_valid || sums_due.size() != 0);
    endtask

    // Fully idle: no sums due and any item without a result has finished too.
    task automatic quiesce();
        wait_all_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [SAMPLE_W-1:0] pick_value(int mode);
        case (mode)
            0:       return SAMPLE_W'($urandom_range(0, VALUE_RANGE_DEF - 1));
            1:       return palette[$urandom_range(0, 2)];
            // values at both ends of the range
            default: return SAMPLE_W'(($urandom_range(0, 1) ? 63 : 0) ^ $urandom_range(0, 1));
        endcase
    endfunction

    initial
    begin
        int wl;
        int tc;
        int phase_len;
        int mode;
        int random_items;
        int phases;
        random_items = 0;
        phases       = 0;

        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // --- Directed part ---
        // Reset settings: one-value window, top one value.
        queue_sample(6'd0, 1'b0);
        queue_sample(6'd63, 1'b0);
        queue_sample(6'd63, 1'b1);      // start on a one-value window
        quiesce();

        // Zero window length acts as one; zero top count gives a zero sum.
        write_reg(CFG_TOP_COUNT, 7'd0);
        write_reg(CFG_WINDOW_LENGTH, 7'd0);
        queue_sample(6'd63, 1'b0);
        queue_sample(6'd5, 1'b1);
        quiesce();

        // Tied counts: higher value ranks first.
        write_reg(CFG_WINDOW_LENGTH, 7'd4);
        write_reg(CFG_TOP_COUNT, 7'd2);
        queue_sample(6'd7, 1'b0);
        queue_sample(6'd7, 1'b0);
        queue_sample(6'd3, 1'b0);
        queue_sample(6'd3, 1'b0);
        queue_sample(6'd9, 1'b0);
        queue_sample(6'd9, 1'b0);
        queue_sample(6'd1, 1'b1);       // restart mid-stream, window refills
        queue_sample(6'd2, 1'b0);
        queue_sample(6'd2, 1'b0);
        queue_sample(6'd2, 1'b0);
        quiesce();

        // Top count above the bound, fewer distinct values than picks.
        write_reg(CFG_TOP_COUNT, 7'd31);
        write_reg(CFG_WINDOW_LENGTH, 7'd3);
        queue_sample(6'd0, 1'b0);
        queue_sample(6'd63, 1'b0);
        queue_sample(6'd62, 1'b0);
        queue_sample(6'd63, 1'b0);
        quiesce();

        // --- Random phases ---
        while (random_items < RANDOM_ITEMS)
        begin
            phases++;
            no_idle = ($urandom_range(0, 5) == 0);

            // Window length: mostly short, sometimes the extremes or saturating.
            case ($urandom_range(0, 9))
                0:       wl = ($urandom_range(0, 3) == 0) ? 0 :
                              ($urandom_range(0, 2) == 0) ? 1 :
                              ($urandom_range(0, 1) ? 64 : 127);
                1:       wl = $urandom_range(65, 127);
                2:       wl = $urandom_range(40, 64);
                default: wl = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 5))
                0:       tc = ($urandom_range(0, 3) == 0) ? 0 :
                              ($urandom_range(0, 2) == 0) ? 1 :
                              ($urandom_range(0, 1) ? 16 : 31);
                1:       tc = $urandom_range(17, 31);
                default: tc = $urandom_range(1, 8);
            endcase

            // Upper data bits are ignored for top count, so let them toggle.
            write_reg(CFG_TOP_COUNT, {2'($urandom_range(0, 3)), 5'(tc)});
            // Now and then keep the running sequence and change only top count.
            if (phases == 1 || $urandom_range(0, 3) != 0)
                write_reg(CFG_WINDOW_LENGTH, 7'(wl));

            mode = $urandom_range(0, 2);
            foreach (palette[i])
                palette[i] = SAMPLE_W'($urandom_range(0, VALUE_RANGE_DEF - 1));

            if (wl == 0)
                wl = 1;
            if (wl > MAX_WINDOW_DEF)
                wl = MAX_WINDOW_DEF;
            phase_len = wl + $urandom_range(5, 60);

            // Long receiver hold-off while the sender keeps offering items.
            if (phases % 9 == 3)
                hold_requests++;

            for (int k = 0; k < phase_len; k++)
            begin
                queue_sample(pick_value(mode), $urandom_range(0, 49) == 0);
                // Sender pauses mid-sequence until everything is back.
                if (phases % 7 == 5 && k == phase_len / 2)
                    wait_all_results();
            end
            random_items += phase_len;
            quiesce();
        end

        quiesce();
        if (sums_due.size() != 0)
        begin
            $error("window_sum: %0d expected results never arrived", sums_due.size());
            fails++;
        end

        $display("Covered %0d items, %0d sums, %0d register writes, %0d sequence starts,",
                 items_in, results_out, cfg_writes, starts_taken);
        $display("%0d random phases with %0d long output hold-offs; %0d mismatches.",
                 phases, long_holds, fails);
        if (fails == 0)
            $display("[sliding_window_top_x_frequency_sum] OK");
        else
            $display("[sliding_window_top_x_frequency_sum] ERROR");
        $finish;
    end

endmodule
